@@ hdl/lpfd_pkg.sv @@
// lpfd_pkg: shared types, constants and the frame prefix table for the frame decoder
// used by the channel interfaces, the decode core, the top level and the checker
// no dependencies

package lpfd_pkg;

  // header layout
  localparam logic [3:0] HEADER_BYTES = 4'd12;
  localparam logic [3:0] PREFIX_BYTES = 4'd8;

  // budget after reset
  localparam logic [31:0] MAX_FRAME_BYTES_RST = 32'd65536;

  // result status codes
  typedef enum logic [2:0] {
    STATUS_HEADER     = 3'd0,
    STATUS_BODY       = 3'd1,
    STATUS_BAD_PREFIX = 3'd2,
    STATUS_BUDGET     = 3'd3,
    STATUS_CLOSED     = 3'd4
  } status_t;

  // one result word
  typedef struct packed {
    status_t    status;
    logic [7:0] body_byte;
    logic       frame_last;
  } result_t;

  // fixed frame prefix, one byte per prefix position
  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h4F;
      3'd1:    b = 8'h43;
      3'd2:    b = 8'h4B;
      3'd3:    b = 8'h31;
      3'd4:    b = 8'h00;
      3'd5:    b = 8'h01;
      3'd6:    b = 8'h00;
      3'd7:    b = 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/lpfd_if.sv @@
// lpfd channel interfaces: input byte stream, result stream, budget write channel
// depends on lpfd_pkg for the status type

// raw stream byte
interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// decode result
interface lpfd_out_if;
  logic              valid;
  logic              ready;
  lpfd_pkg::status_t status;
  logic [7:0]        body_byte;
  logic              frame_last;

  modport source (output valid, output status, output body_byte, output frame_last,
                  input ready);
  modport sink (input valid, input status, input body_byte, input frame_last,
                output ready);
endinterface

// budget register write
interface lpfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/lpfd_core.sv @@
// lpfd_core: per-byte header/body decode and the frame state registers
// depends on lpfd_pkg (status codes, result struct, prefix table)

module lpfd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  logic [7:0]        data_byte,
  input  logic [31:0]       max_frame_bytes,
  output lpfd_pkg::result_t result
);

  logic [3:0]  header_count, header_count_next;
  logic        prefix_mismatch, prefix_mismatch_next;
  logic [31:0] frame_length, frame_length_next;
  logic [31:0] body_count, body_count_next;
  logic        stream_closed, stream_closed_next;
  logic [31:0] body_count_inc;

  assign body_count_inc = body_count + 32'd1;

  // decode one byte against the current frame state
  always_comb begin
    header_count_next    = header_count;
    prefix_mismatch_next = prefix_mismatch;
    frame_length_next    = frame_length;
    body_count_next      = body_count;
    stream_closed_next   = stream_closed;
    result.status        = lpfd_pkg::STATUS_HEADER;
    result.body_byte     = 8'h00;
    result.frame_last    = 1'b0;

    if (stream_closed) begin
      result.status = lpfd_pkg::STATUS_CLOSED;
    end else if (header_count < lpfd_pkg::HEADER_BYTES) begin
      // header byte: prefix compare or length shift-in
      if (header_count < lpfd_pkg::PREFIX_BYTES) begin
        if (data_byte != lpfd_pkg::prefix_byte(header_count[2:0])) begin
          prefix_mismatch_next = 1'b1;
        end
      end else begin
        frame_length_next = {frame_length[23:0], data_byte};
      end
      header_count_next = header_count + 4'd1;
      // judge the header on its last byte, prefix error first
      if (header_count_next == lpfd_pkg::HEADER_BYTES) begin
        body_count_next = 32'd0;
        if (prefix_mismatch_next) begin
          stream_closed_next = 1'b1;
          result.status      = lpfd_pkg::STATUS_BAD_PREFIX;
        end else if (frame_length_next == 32'd0 || frame_length_next > max_frame_bytes) begin
          stream_closed_next = 1'b1;
          result.status      = lpfd_pkg::STATUS_BUDGET;
        end
      end
    end else begin
      // body byte passes through
      result.status    = lpfd_pkg::STATUS_BODY;
      result.body_byte = data_byte;
      body_count_next  = body_count_inc;
      if (body_count_inc >= frame_length) begin
        result.frame_last    = 1'b1;
        header_count_next    = 4'd0;
        prefix_mismatch_next = 1'b0;
        frame_length_next    = 32'd0;
        body_count_next      = 32'd0;
      end
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= 4'd0;
      prefix_mismatch <= 1'b0;
      frame_length    <= 32'd0;
      body_count      <= 32'd0;
      stream_closed   <= 1'b0;
    end else if (step_en) begin
      header_count    <= header_count_next;
      prefix_mismatch <= prefix_mismatch_next;
      frame_length    <= frame_length_next;
      body_count      <= body_count_next;
      stream_closed   <= stream_closed_next;
    end
  end

endmodule

@@ hdl/length_prefixed_frame_decoder.sv @@
// length_prefixed_frame_decoder: top level, input and result registers around lpfd_core
// depends on lpfd_pkg, lpfd_if.sv (channel interfaces) and lpfd_core
//
//   channel  dir  payload                              words
//   din      in   data_byte[7:0]                       one per stream byte
//   dout     out  status[2:0] body_byte[7:0] frame_last one per din word
//   cfg      in   data[31:0] -> max_frame_bytes         budget write, always ready
//
// a word passes from din through the input register, then the decode logic, into the
// result register and out on dout; one word per cycle sustained while dout is ready
// the decode state advances when a word moves from the input to the result register
// a stall on dout holds the result register and then the input register; din
// backs up only when both are full
// synchronous reset clears all control state and sets the budget to 65536

module length_prefixed_frame_decoder (
  input  logic            clk,
  input  logic            rst,
  lpfd_in_if.sink         din,
  lpfd_out_if.source      dout,
  lpfd_cfg_if.sink        cfg
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_valid;
  lpfd_pkg::result_t out_result;
  lpfd_pkg::result_t step_result;
  logic [31:0]       max_frame_bytes;
  logic              advance;

  // input register moves on when the result register is free or draining
  assign advance  = in_valid && (!out_valid || dout.ready);
  assign din.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  // budget register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_bytes <= lpfd_pkg::MAX_FRAME_BYTES_RST;
    end else if (cfg.valid) begin
      max_frame_bytes <= cfg.data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (din.ready) begin
      in_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_byte <= din.data_byte;
    end
  end

  // decode logic and frame state
  lpfd_core u_core (
    .clk             (clk),
    .rst             (rst),
    .step_en         (advance),
    .data_byte       (in_byte),
    .max_frame_bytes (max_frame_bytes),
    .result          (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.status     = out_result.status;
  assign dout.body_byte  = out_result.body_byte;
  assign dout.frame_last = out_result.frame_last;

endmodule

@@ hdl/lpfd_checker.sv @@
// lpfd_checker: port-level assertions for the frame decoder, bound to the top level
// depends on lpfd_pkg for status codes

module lpfd_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input lpfd_pkg::status_t status,
  input logic [7:0]        body_byte,
  input logic              frame_last
);

  logic closed_seen;

  // remember that an error or closed word has been delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      closed_seen <= 1'b0;
    end else if (out_valid && out_ready && (status == lpfd_pkg::STATUS_BAD_PREFIX ||
                 status == lpfd_pkg::STATUS_BUDGET || status == lpfd_pkg::STATUS_CLOSED)) begin
      closed_seen <= 1'b1;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(body_byte)
      && $stable(frame_last))
    else $error("result changed while stalled");

  // pass-through fields are zero outside body words
  a_body_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lpfd_pkg::STATUS_BODY |-> body_byte == 8'h00 && !frame_last)
    else $error("body fields set on a non-body word");

  // after an error every word reports closed
  a_stay_closed: assert property (@(posedge clk) disable iff (rst)
    out_valid && closed_seen |-> status == lpfd_pkg::STATUS_CLOSED)
    else $error("word after error is not closed");

  // errors are reported once, later words only say closed
  a_error_once: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == lpfd_pkg::STATUS_BAD_PREFIX || status == lpfd_pkg::STATUS_BUDGET)
      |-> !closed_seen)
    else $error("second error report");

endmodule

bind length_prefixed_frame_decoder lpfd_checker u_lpfd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .status     (dout.status),
  .body_byte  (dout.body_byte),
  .frame_last (dout.frame_last)
);
